@@ design/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   localparam int DISPLAY_COLUMNS      = 250;
   localparam int SUBPIXELS_PER_COLUMN = 2;
   localparam int TEXT_CAPACITY        = 80;
   localparam int GLYPH_STORE_DEPTH    = 1024;

   localparam int RING_LEN    = DISPLAY_COLUMNS * SUBPIXELS_PER_COLUMN;
   localparam int GLYPH_COUNT = 96;
   localparam int RING_AW     = $clog2(RING_LEN);
   localparam int SUM_W       = $clog2(2 * RING_LEN);
   localparam int COL_W       = $clog2(DISPLAY_COLUMNS + 1);
   localparam int TXT_AW      = (TEXT_CAPACITY > 1) ? $clog2(TEXT_CAPACITY) : 1;
   localparam int TXT_CW      = $clog2(TEXT_CAPACITY + 1);
   localparam int GLYPH_AW    = $clog2(GLYPH_STORE_DEPTH);
   localparam int SUB_W       = (SUBPIXELS_PER_COLUMN > 1) ? $clog2(SUBPIXELS_PER_COLUMN) : 1;
   localparam int GS_AW       = 7;
   localparam int GS_W        = 11;

   localparam logic [7:0] FRAME_MARK      = 8'hA5;
   localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;
   localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
   localparam logic [7:0] SUBST_CHAR      = 8'h5F;

   localparam logic [15:0][2:0] ROW_SKEW = {
      3'd4, 3'd0, 3'd4, 3'd0, 3'd4, 3'd0, 3'd5, 3'd0,
      3'd6, 3'd0, 3'd6, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0
   };

   typedef enum logic [1:0] {
      CMD_FONT_INDEX  = 2'd0,
      CMD_FONT_COLUMN = 2'd1,
      CMD_RX_BYTE     = 2'd2,
      CMD_TICK        = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_ACCEPT, OP_CLEAR, OP_TICK, OP_RSP, OP_RINIT, OP_TXT_RD,
      OP_ST0, OP_ST1, OP_LEN, OP_COL_RD, OP_COL_LATCH, OP_PIX_RD, OP_PIX_WR,
      OP_PIX_SKIP, OP_COL_NEXT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR, ST_IDLE, ST_TICK, ST_RSP, ST_RINIT, ST_RCLR, ST_TXT,
      ST_ST0, ST_ST1, ST_LEN, ST_COL, ST_COLL, ST_PIX, ST_PIXWR, ST_COLN
   } state_type;

   typedef struct packed {
      logic clr_last;
      logic tick_cmd;
      logic render_req;
      logic txt_done;
      logic len_done;
      logic pix_lit;
      logic pix_last;
   } dp_status_type;

endpackage

@@ design/ptrs_datapath.sv @@
// ----------------------------------------------------------------------------
// ptrs_datapath
// Stores, counters and render arithmetic, stepped by the controller op code.
// ----------------------------------------------------------------------------
module ptrs_datapath import ptrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     op,
   input  logic [1:0]    req_cmd,
   input  logic [9:0]    req_font_addr,
   input  logic [15:0]   req_font_word,
   input  logic [7:0]    req_rx_byte,
   output dp_status_type status,
   output logic          rsp_strobe,
   output logic [15:0]   rsp_column_bits,
   output logic [8:0]    rsp_scan_pos,
   output logic          rsp_packet_open
);

   logic [7:0]        text_mem [TEXT_CAPACITY];
   logic [GS_W-1:0]   start_mem [GLYPH_COUNT];
   logic [15:0]       glyph_mem [GLYPH_STORE_DEPTH];
   logic [15:0]       ring_mem [RING_LEN];

   logic [7:0]        text_q;
   logic [GS_W-1:0]   start_q;
   logic [15:0]       glyph_q;
   logic [15:0]       ring_q;

   logic [TXT_CW-1:0]  text_count_ff, text_count_in;
   logic               in_frame_ff, in_frame_in;
   logic [RING_AW-1:0] scan_ff, scan_in;
   logic [RING_AW-1:0] clr_ff, clr_in;
   logic [RING_AW-1:0] pos_ff, pos_in;
   logic               tick_ff, tick_in;
   logic [TXT_CW-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [GS_AW-1:0]   g_ff, g_in;
   logic [GS_W-1:0]    first_ff, first_in;
   logic [GS_W-1:0]    len_ff, len_in;
   logic [GS_W-1:0]    k_ff, k_in;
   logic               oob_ff, oob_in;
   logic [15:0]        bits_ff, bits_in;
   logic [3:0]         row_ff, row_in;
   logic [SUB_W-1:0]   sub_ff, sub_in;
   logic               strobe_ff, strobe_in;
   logic [15:0]        colbits_ff, colbits_in;
   logic [8:0]         spos_ff, spos_in;
   logic               popen_ff, popen_in;

   logic               accept_write;
   logic [7:0]         ch;
   logic [GS_W-1:0]    glen;
   logic [GS_W-1:0]    remain;
   logic [GS_W:0]      gaddr;
   logic [SUM_W-1:0]   sp_sum;
   logic [RING_AW-1:0] sp;
   logic [RING_AW-1:0] ring_raddr;
   logic               ring_we;
   logic [RING_AW-1:0] ring_waddr;
   logic [15:0]        ring_wdata;
   logic [11:0]        fcol_addr;

   assign accept_write = (op == OP_ACCEPT);
   assign fcol_addr    = {2'b00, req_font_addr};

   // Map non-printable characters onto the substitute glyph.
   always_comb begin
      ch = text_q;
      if (text_q < FIRST_PRINTABLE || text_q > LAST_PRINTABLE) begin
         ch = SUBST_CHAR;
      end
   end

   assign glen   = start_q - first_ff;
   assign remain = GS_W'(DISPLAY_COLUMNS) - GS_W'(col_ff);
   assign gaddr  = {1'b0, first_ff} + {1'b0, k_ff};

   always_comb begin
      sp_sum = SUM_W'(col_ff) * SUM_W'(SUBPIXELS_PER_COLUMN) + SUM_W'(sub_ff)
             + SUM_W'(RING_LEN) - SUM_W'(ROW_SKEW[row_ff]);
      if (sp_sum >= SUM_W'(RING_LEN)) begin
         sp_sum = sp_sum - SUM_W'(RING_LEN);
      end
      sp = sp_sum[RING_AW-1:0];
   end

   assign ring_raddr = (op == OP_TICK) ? scan_ff : sp;
   assign ring_we    = (op == OP_CLEAR) || (op == OP_PIX_WR);
   assign ring_waddr = (op == OP_CLEAR) ? clr_ff : sp;
   assign ring_wdata = (op == OP_CLEAR) ? 16'h0000 : (ring_q | (16'h0001 << row_ff));

   // Memories
   always_ff @(posedge clock) begin
      if (accept_write && req_cmd == CMD_RX_BYTE && req_rx_byte != 8'h00
          && req_rx_byte != FRAME_MARK && text_count_ff < TXT_CW'(TEXT_CAPACITY)) begin
         text_mem[text_count_ff[TXT_AW-1:0]] <= req_rx_byte;
      end
      text_q <= text_mem[idx_ff[TXT_AW-1:0]];
   end

   // Read at the next glyph index so that start_q follows g_ff with no lag.
   always_ff @(posedge clock) begin
      if (accept_write && req_cmd == CMD_FONT_INDEX && req_font_addr < 10'(GLYPH_COUNT)) begin
         start_mem[req_font_addr[GS_AW-1:0]] <= req_font_word[GS_W-1:0];
      end
      start_q <= start_mem[g_in];
   end

   always_ff @(posedge clock) begin
      if (accept_write && req_cmd == CMD_FONT_COLUMN
          && fcol_addr < 12'(GLYPH_STORE_DEPTH)) begin
         glyph_mem[fcol_addr[GLYPH_AW-1:0]] <= req_font_word;
      end
      glyph_q <= glyph_mem[gaddr[GLYPH_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_q <= ring_mem[ring_raddr];
   end

   // Register next values
   always_comb begin
      text_count_in = text_count_ff;
      in_frame_in   = in_frame_ff;
      scan_in       = scan_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      tick_in       = tick_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      g_in          = g_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      oob_in        = oob_ff;
      bits_in       = bits_ff;
      row_in        = row_ff;
      sub_in        = sub_ff;
      strobe_in     = 1'b0;
      colbits_in    = colbits_ff;
      spos_in       = spos_ff;
      popen_in      = popen_ff;
      unique case (op)
         OP_ACCEPT: begin
            tick_in = (req_cmd == CMD_TICK);
            if (req_cmd == CMD_RX_BYTE) begin
               if (req_rx_byte == 8'h00) begin
                  in_frame_in = 1'b0;
               end else if (req_rx_byte == FRAME_MARK) begin
                  in_frame_in   = 1'b1;
                  text_count_in = '0;
               end else if (text_count_ff < TXT_CW'(TEXT_CAPACITY)) begin
                  text_count_in = text_count_ff + 1'b1;
               end
            end
         end
         OP_CLEAR: clr_in = clr_ff + 1'b1;
         OP_TICK: begin
            pos_in  = scan_ff;
            scan_in = (scan_ff == RING_AW'(RING_LEN - 1)) ? '0 : scan_ff + 1'b1;
         end
         OP_RSP: begin
            strobe_in  = 1'b1;
            colbits_in = tick_ff ? ring_q : 16'h0000;
            spos_in    = tick_ff ? 9'(pos_ff) : 9'd0;
            popen_in   = in_frame_ff;
         end
         OP_RINIT: begin
            clr_in = '0;
            idx_in = '0;
            col_in = '0;
         end
         OP_TXT_RD: ;
         OP_ST0: g_in = GS_AW'(ch - FIRST_PRINTABLE);
         OP_ST1: begin
            first_in = start_q;
            g_in     = g_ff + 1'b1;
         end
         OP_LEN: begin
            len_in = (glen > remain) ? remain : glen;
            k_in   = '0;
         end
         OP_COL_RD: oob_in = (gaddr >= (GS_W+1)'(GLYPH_STORE_DEPTH));
         OP_COL_LATCH: begin
            bits_in = oob_ff ? 16'h0000 : glyph_q;
            row_in  = '0;
            sub_in  = '0;
         end
         OP_PIX_WR, OP_PIX_SKIP: begin
            if (sub_ff == SUB_W'(SUBPIXELS_PER_COLUMN - 1)) begin
               sub_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         OP_COL_NEXT: begin
            k_in   = k_ff + 1'b1;
            col_in = col_ff + 1'b1;
         end
         OP_PIX_RD: ;
         OP_IDLE: begin
            // Hold the character index when a glyph is done.
            if (k_ff == len_ff) begin
               idx_in = idx_ff;
            end
         end
         default: ;
      endcase
      // The character index steps on OP_LEN; this OP_IDLE term is tied off and never fires.
      if (op == OP_IDLE && status.len_done && !status.txt_done && !tick_ff
          && col_ff != '0 && 1'b0) begin
         idx_in = idx_ff + 1'b1;
      end
      if (op == OP_LEN) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_count_ff <= TXT_CW'(TEXT_CAPACITY);
         in_frame_ff   <= 1'b0;
         scan_ff       <= '0;
         clr_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         text_count_ff <= text_count_in;
         in_frame_ff   <= in_frame_in;
         scan_ff       <= scan_in;
         clr_ff        <= clr_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      tick_ff    <= tick_in;
      idx_ff     <= idx_in;
      col_ff     <= col_in;
      g_ff       <= g_in;
      first_ff   <= first_in;
      len_ff     <= len_in;
      k_ff       <= k_in;
      oob_ff     <= oob_in;
      bits_ff    <= bits_in;
      row_ff     <= row_in;
      sub_ff     <= sub_in;
      colbits_ff <= colbits_in;
      spos_ff    <= spos_in;
      popen_ff   <= popen_in;
   end

   assign status.clr_last   = (clr_ff == RING_AW'(RING_LEN - 1));
   assign status.tick_cmd   = (req_cmd == CMD_TICK);
   assign status.render_req = (req_cmd == CMD_RX_BYTE) && (req_rx_byte == 8'h00) && in_frame_ff;
   assign status.txt_done   = (idx_ff >= text_count_ff);
   assign status.len_done   = (k_ff == len_ff);
   assign status.pix_lit    = bits_ff[4'd15 - row_ff];
   assign status.pix_last   = (row_ff == 4'd15) && (sub_ff == SUB_W'(SUBPIXELS_PER_COLUMN - 1));

   assign rsp_strobe      = strobe_ff;
   assign rsp_column_bits = colbits_ff;
   assign rsp_scan_pos    = spos_ff;
   assign rsp_packet_open = popen_ff;

endmodule

@@ design/ptrs_controller.sv @@
// ----------------------------------------------------------------------------
// ptrs_controller
// Sequencer for start-up clear, request handling, ticks and text rendering.
// ----------------------------------------------------------------------------
module ptrs_controller import ptrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_op_type     op,
   output logic          busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_CLR: if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               if (status.tick_cmd) begin
                  state_in = ST_TICK;
               end else if (status.render_req) begin
                  state_in = ST_RINIT;
               end else begin
                  state_in = ST_RSP;
               end
            end
         end
         ST_TICK:  state_in = ST_RSP;
         ST_RSP:   state_in = ST_IDLE;
         ST_RINIT: state_in = ST_RCLR;
         ST_RCLR:  if (status.clr_last) state_in = ST_TXT;
         ST_TXT:   state_in = status.txt_done ? ST_RSP : ST_ST0;
         ST_ST0:   state_in = ST_ST1;
         ST_ST1:   state_in = ST_LEN;
         ST_LEN:   state_in = ST_COL;
         ST_COL:   state_in = status.len_done ? ST_TXT : ST_COLL;
         ST_COLL:  state_in = ST_PIX;
         ST_PIX: begin
            if (status.pix_lit) begin
               state_in = ST_PIXWR;
            end else if (status.pix_last) begin
               state_in = ST_COLN;
            end
         end
         ST_PIXWR: state_in = status.pix_last ? ST_COLN : ST_PIX;
         ST_COLN:  state_in = ST_COL;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op   = OP_IDLE;
      busy = 1'b1;
      unique case (state_ff)
         ST_INIT_CLR: op = OP_CLEAR;
         ST_IDLE: begin
            busy = 1'b0;
            if (start) op = OP_ACCEPT;
         end
         ST_TICK:  op = OP_TICK;
         ST_RSP:   op = OP_RSP;
         ST_RINIT: op = OP_RINIT;
         ST_RCLR:  op = OP_CLEAR;
         ST_TXT:   op = status.txt_done ? OP_IDLE : OP_TXT_RD;
         ST_ST0:   op = OP_ST0;
         ST_ST1:   op = OP_ST1;
         ST_LEN:   op = OP_LEN;
         ST_COL:   op = status.len_done ? OP_IDLE : OP_COL_RD;
         ST_COLL:  op = OP_COL_LATCH;
         ST_PIX:   op = status.pix_lit ? OP_PIX_RD : OP_PIX_SKIP;
         ST_PIXWR: op = OP_PIX_WR;
         ST_COLN:  op = OP_COL_NEXT;
         default:  op = OP_IDLE;
      endcase
   end

endmodule

@@ design/pov_text_render_and_scan_top.sv @@
// ----------------------------------------------------------------------------
// pov_text_render_and_scan_top
// Column engine for a persistence-of-vision display: font load, text framing,
// rendering into the column ring and tick-driven column scan.
// ----------------------------------------------------------------------------
// A font write, byte or ordinary request gives its strobe from the RSP state via the
// strobe register; a tick passes the TICK state first. The next request can be
// taken in the strobe cycle. A closing byte renders: ring clear over all 500
// entries, a fetch per character, then per glyph column a step per subpixel plus a
// write per lit subpixel (read-modify-write). Reset clears the ring with busy high.
// Results cannot be stalled: each strobe lasts one cycle.
module pov_text_render_and_scan_top import ptrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_font_addr,
   input  logic [15:0] req_font_word,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_strobe,
   output logic [15:0] rsp_column_bits,
   output logic [8:0]  rsp_scan_pos,
   output logic        rsp_packet_open
);

   dp_op_type     op;
   dp_status_type status;

   ptrs_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   ptrs_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_cmd         (req_cmd),
      .req_font_addr   (req_font_addr),
      .req_font_word   (req_font_word),
      .req_rx_byte     (req_rx_byte),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_column_bits (rsp_column_bits),
      .rsp_scan_pos    (rsp_scan_pos),
      .rsp_packet_open (rsp_packet_open)
   );

endmodule
